@@ rtl/core/frla_pkg.sv @@
// ----------------------------------------------------------------------------
// frla_pkg
// Shared types, constants and helpers of the frequency-ranked key list.
// ----------------------------------------------------------------------------
package frla_pkg;

   localparam int CAPACITY_DEFAULT = 32;
   localparam int KEY_BITS_DEFAULT = 16;

   localparam int KEY_FIELD_BITS = 16;
   localparam int RANK_BITS      = 5;
   localparam int COUNT_BITS     = 16;

   typedef logic [COUNT_BITS-1:0] count_type;

   localparam count_type COUNT_MAX       = 16'hFFFF;
   localparam count_type AGE_LIMIT_RESET = 16'h8000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_PREP,
      ST_UPDATE,
      ST_DONE
   } ctrl_state_type;

   // Per-cell control and count payload that moves along the chain.
   typedef struct packed {
      logic      shift_en;
      count_type count;
   } chain_ctl_type;

   // Aging rule: counts are halved, and anything that would drop below one is one.
   function automatic count_type halve_count(input count_type value);
      count_type result;
      if (value > count_type'(1)) begin
         result = value >> 1;
      end else begin
         result = count_type'(1);
      end
      return result;
   endfunction

endpackage

@@ rtl/core/frla_if.sv @@
// ----------------------------------------------------------------------------
// frla_req_if / frla_rsp_if
// Valid/ready channels for key requests and their results.
// ----------------------------------------------------------------------------
interface frla_req_if;
   logic                                valid;
   logic                                ready;
   logic [frla_pkg::KEY_FIELD_BITS-1:0] key;

   modport source (output valid, output key, input ready);
   modport sink   (input valid, input key, output ready);
endinterface

interface frla_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                hit;
   logic [frla_pkg::RANK_BITS-1:0]      rank;
   logic                                evicted;
   logic [frla_pkg::KEY_FIELD_BITS-1:0] evicted_key;
   logic                                aged;

   modport source (output valid, output hit, output rank, output evicted,
                   output evicted_key, output aged, input ready);
   modport sink   (input valid, input hit, input rank, input evicted,
                   input evicted_key, input aged, output ready);
endinterface

@@ rtl/core/frequency_ranked_list_with_aging_core.sv @@
// ----------------------------------------------------------------------------
// frequency_ranked_list_with_aging_core
// Use-count ranked key list with count halving, built as a rotating cell ring.
// ----------------------------------------------------------------------------
// A request accepted in the idle state is searched in a first turn of the ring,
// prepared, rewritten in a second turn and its result registered in the done
// state; no new request is accepted until the sequencer is back in idle.
// Reset (synchronous, active high) empties the list, sets age_limit to 0x8000
// and drops any pending result; list storage itself is not cleared.
// ----------------------------------------------------------------------------
module frequency_ranked_list_with_aging_core #(
   parameter int CAPACITY = frla_pkg::CAPACITY_DEFAULT,
   parameter int KEY_BITS = frla_pkg::KEY_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   frla_req_if.sink                        req_ch,
   frla_rsp_if.source                      rsp_ch,
   input  logic                            csr_wr_en,
   input  logic [frla_pkg::COUNT_BITS-1:0] csr_wr_data
);

   // The list lives in a ring of CAPACITY cells. While a pass (search or update)
   // runs, every cell takes its upper neighbor's content each cycle, so the entry at
   // list position j sits in cell 0 during step j of a pass. After CAPACITY
   // steps the ring is back in its original alignment.
   //
   // The first pass only looks: it finds the key, its position and count, and
   // picks up the entry in the last cell as the candidate for eviction.
   // The preparation state then works out the new count of the moving entry,
   // whether the list ages, and where the moving entry starts from (its old
   // position on a hit, the end of the list on a miss).
   //
   // The second pass rewrites the list at the tail of the ring. Counts are
   // halved on the fly when the list ages. Since the list stays sorted by
   // count, the moving entry is dropped in at the first position whose count
   // is not greater than its own; the entries behind it slide down by one
   // through a one-entry hold register until its old position, where the old
   // copy (or the dropped last entry) is discarded.

   logic [KEY_BITS-1:0]     cell_key   [CAPACITY];
   frla_pkg::count_type     cell_count [CAPACITY];
   frla_pkg::chain_ctl_type cell_ctl   [CAPACITY];
   logic [KEY_BITS-1:0]     cell_key_in[CAPACITY];

   logic [KEY_BITS-1:0]     tail_key;
   frla_pkg::chain_ctl_type tail_ctl;

   frla_ctrl #(
      .CAPACITY(CAPACITY),
      .KEY_BITS(KEY_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .head_key    (cell_key[0]),
      .head_count  (cell_count[0]),
      .tail_key    (tail_key),
      .tail_ctl    (tail_ctl)
   );

   // Each cell is fed by its upper neighbor; the top cell is fed by the
   // sequencer's tail unit.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == CAPACITY - 1) begin : g_top
         assign cell_ctl[i]    = tail_ctl;
         assign cell_key_in[i] = tail_key;
      end else begin : g_mid
         assign cell_ctl[i].shift_en = tail_ctl.shift_en;
         assign cell_ctl[i].count    = cell_count[i+1];
         assign cell_key_in[i]       = cell_key[i+1];
      end

      frla_cell #(
         .KEY_BITS(KEY_BITS)
      ) u_cell (
         .clock     (clock),
         .ctl_in    (cell_ctl[i]),
         .key_in    (cell_key_in[i]),
         .key_out   (cell_key[i]),
         .count_out (cell_count[i])
      );
   end

endmodule

@@ rtl/core/frla_cell.sv @@
// ----------------------------------------------------------------------------
// frla_cell
// One list slot: a key and its use count, loaded from the neighbor on shift.
// ----------------------------------------------------------------------------
module frla_cell #(
   parameter int KEY_BITS = frla_pkg::KEY_BITS_DEFAULT
) (
   input  logic                    clock,
   input  frla_pkg::chain_ctl_type ctl_in,
   input  logic [KEY_BITS-1:0]     key_in,
   output logic [KEY_BITS-1:0]     key_out,
   output frla_pkg::count_type     count_out
);

   logic [KEY_BITS-1:0] key_ff;
   logic [KEY_BITS-1:0] key_load_in;
   frla_pkg::count_type count_ff;
   frla_pkg::count_type count_load_in;

   always_comb begin
      if (ctl_in.shift_en) begin
         key_load_in   = key_in;
         count_load_in = ctl_in.count;
      end else begin
         key_load_in   = key_ff;
         count_load_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_load_in;
      count_ff <= count_load_in;
   end

   assign key_out   = key_ff;
   assign count_out = count_ff;

endmodule

@@ rtl/core/frla_ctrl.sv @@
// ----------------------------------------------------------------------------
// frla_ctrl
// Sequencer and tail unit: searches the rotating list, then rewrites it.
// ----------------------------------------------------------------------------
module frla_ctrl #(
   parameter int CAPACITY = frla_pkg::CAPACITY_DEFAULT,
   parameter int KEY_BITS = frla_pkg::KEY_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   frla_req_if.sink                            req_ch,
   frla_rsp_if.source                          rsp_ch,
   input  logic                                csr_wr_en,
   input  logic [frla_pkg::COUNT_BITS-1:0]     csr_wr_data,
   input  logic [KEY_BITS-1:0]                 head_key,
   input  frla_pkg::count_type                 head_count,
   output logic [KEY_BITS-1:0]                 tail_key,
   output frla_pkg::chain_ctl_type             tail_ctl
);

   localparam int IDX_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int FILL_BITS = $clog2(CAPACITY + 1);
   localparam logic [IDX_BITS-1:0]  LAST_IDX = IDX_BITS'(CAPACITY - 1);
   localparam logic [FILL_BITS-1:0] FULL     = FILL_BITS'(CAPACITY);

   frla_pkg::ctrl_state_type state_ff, state_in;

   logic [IDX_BITS-1:0]  j_ff, j_in;
   logic [FILL_BITS-1:0] fill_ff, fill_in;
   frla_pkg::count_type  age_limit_ff, age_limit_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic                found_ff, found_in;
   logic [IDX_BITS-1:0] pos_ff, pos_in;
   frla_pkg::count_type cnt_ff, cnt_in;
   logic [KEY_BITS-1:0] evk_ff, evk_in;
   frla_pkg::count_type mcount_ff, mcount_in;
   logic [IDX_BITS-1:0] p_ff, p_in;
   logic                aged_ff, aged_in;
   logic                evicted_ff, evicted_in;
   logic                ins_ff, ins_in;
   logic [KEY_BITS-1:0] hold_key_ff, hold_key_in;
   frla_pkg::count_type hold_cnt_ff, hold_cnt_in;
   logic [IDX_BITS-1:0] rank_ff, rank_in;

   logic                                rsp_hit_ff, rsp_hit_in;
   logic [frla_pkg::RANK_BITS-1:0]      rsp_rank_ff, rsp_rank_in;
   logic                                rsp_evicted_ff, rsp_evicted_in;
   logic [frla_pkg::KEY_FIELD_BITS-1:0] rsp_evkey_ff, rsp_evkey_in;
   logic                                rsp_aged_ff, rsp_aged_in;

   logic                shift_en;
   logic                accept;
   logic                load_rsp;
   logic                last_step;
   frla_pkg::count_type cnt_next;
   frla_pkg::count_type head_view;
   logic                j_valid;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         frla_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = frla_pkg::ST_SEARCH;
            end
         end
         frla_pkg::ST_SEARCH: begin
            if (last_step) begin
               state_in = frla_pkg::ST_PREP;
            end
         end
         frla_pkg::ST_PREP: begin
            state_in = frla_pkg::ST_UPDATE;
         end
         frla_pkg::ST_UPDATE: begin
            if (last_step) begin
               state_in = frla_pkg::ST_DONE;
            end
         end
         frla_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               state_in = frla_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = frla_pkg::ST_IDLE;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      req_ch.ready = 1'b0;
      shift_en     = 1'b0;
      load_rsp     = 1'b0;
      case (state_ff)
         frla_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
         end
         frla_pkg::ST_SEARCH: begin
            shift_en = 1'b1;
         end
         frla_pkg::ST_UPDATE: begin
            shift_en = 1'b1;
         end
         frla_pkg::ST_DONE: begin
            load_rsp = !rsp_valid_ff || rsp_ch.ready;
         end
         default: begin
            req_ch.ready = 1'b0;
         end
      endcase
   end

   assign accept    = req_ch.valid && req_ch.ready;
   assign last_step = (j_ff == LAST_IDX);
   assign j_valid   = (FILL_BITS'(j_ff) < fill_ff);
   assign cnt_next  = (cnt_ff == frla_pkg::COUNT_MAX) ? cnt_ff
                                                      : cnt_ff + frla_pkg::count_type'(1);
   assign head_view = aged_ff ? frla_pkg::halve_count(head_count) : head_count;

   // Control registers next values.
   always_comb begin
      j_in         = j_ff;
      fill_in      = fill_ff;
      age_limit_in = age_limit_ff;
      if (shift_en) begin
         j_in = last_step ? '0 : j_ff + IDX_BITS'(1);
      end
      if (csr_wr_en) begin
         age_limit_in = csr_wr_data;
      end
      if (state_ff == frla_pkg::ST_PREP && !found_ff) begin
         if (fill_ff == FULL) begin
            fill_in = FULL;
         end else begin
            fill_in = fill_ff + FILL_BITS'(1);
         end
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Datapath next values and the data fed into the tail of the chain.
   always_comb begin
      key_in      = key_ff;
      found_in    = found_ff;
      pos_in      = pos_ff;
      cnt_in      = cnt_ff;
      evk_in      = evk_ff;
      mcount_in   = mcount_ff;
      p_in        = p_ff;
      aged_in     = aged_ff;
      evicted_in  = evicted_ff;
      ins_in      = ins_ff;
      hold_key_in = hold_key_ff;
      hold_cnt_in = hold_cnt_ff;
      rank_in     = rank_ff;
      tail_key    = head_key;
      tail_ctl.shift_en = shift_en;
      tail_ctl.count    = head_count;

      case (state_ff)
         frla_pkg::ST_IDLE: begin
            if (accept) begin
               key_in   = KEY_BITS'(req_ch.key);
               found_in = 1'b0;
               ins_in   = 1'b0;
            end
         end
         frla_pkg::ST_SEARCH: begin
            if (j_valid && head_key == key_ff && !found_ff) begin
               found_in = 1'b1;
               pos_in   = j_ff;
               cnt_in   = head_count;
            end
            if (last_step) begin
               evk_in = head_key;
            end
         end
         frla_pkg::ST_PREP: begin
            if (found_ff) begin
               evicted_in = 1'b0;
               p_in       = pos_ff;
               aged_in    = cnt_next > age_limit_ff;
               mcount_in  = (cnt_next > age_limit_ff) ? frla_pkg::halve_count(cnt_next)
                                                      : cnt_next;
            end else begin
               evicted_in = (fill_ff == FULL);
               p_in       = (fill_ff == FULL) ? LAST_IDX : IDX_BITS'(fill_ff);
               aged_in    = 1'b0;
               mcount_in  = frla_pkg::count_type'(1);
            end
         end
         frla_pkg::ST_UPDATE: begin
            tail_ctl.count = head_view;
            if (j_ff < p_ff) begin
               if (!ins_ff && head_view <= mcount_ff) begin
                  tail_key       = key_ff;
                  tail_ctl.count = mcount_ff;
                  hold_key_in    = head_key;
                  hold_cnt_in    = head_view;
                  ins_in         = 1'b1;
                  rank_in        = j_ff;
               end else if (ins_ff) begin
                  tail_key       = hold_key_ff;
                  tail_ctl.count = hold_cnt_ff;
                  hold_key_in    = head_key;
                  hold_cnt_in    = head_view;
               end
            end else if (j_ff == p_ff) begin
               // The old copy of the moving entry, or the dropped last entry, leaves here.
               if (!ins_ff) begin
                  tail_key       = key_ff;
                  tail_ctl.count = mcount_ff;
                  ins_in         = 1'b1;
                  rank_in        = j_ff;
               end else begin
                  tail_key       = hold_key_ff;
                  tail_ctl.count = hold_cnt_ff;
               end
            end
         end
         default: begin
            ins_in = ins_ff;
         end
      endcase
   end

   // Result register.
   always_comb begin
      rsp_hit_in     = rsp_hit_ff;
      rsp_rank_in    = rsp_rank_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_evkey_in   = rsp_evkey_ff;
      rsp_aged_in    = rsp_aged_ff;
      if (load_rsp) begin
         rsp_hit_in     = found_ff;
         rsp_rank_in    = frla_pkg::RANK_BITS'(rank_ff);
         rsp_evicted_in = evicted_ff;
         rsp_evkey_in   = evicted_ff ? frla_pkg::KEY_FIELD_BITS'(evk_ff) : '0;
         rsp_aged_in    = aged_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= frla_pkg::ST_IDLE;
         j_ff         <= '0;
         fill_ff      <= '0;
         age_limit_ff <= frla_pkg::AGE_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         j_ff         <= j_in;
         fill_ff      <= fill_in;
         age_limit_ff <= age_limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      found_ff       <= found_in;
      pos_ff         <= pos_in;
      cnt_ff         <= cnt_in;
      evk_ff         <= evk_in;
      mcount_ff      <= mcount_in;
      p_ff           <= p_in;
      aged_ff        <= aged_in;
      evicted_ff     <= evicted_in;
      ins_ff         <= ins_in;
      hold_key_ff    <= hold_key_in;
      hold_cnt_ff    <= hold_cnt_in;
      rank_ff        <= rank_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_rank_ff    <= rsp_rank_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_evkey_ff   <= rsp_evkey_in;
      rsp_aged_ff    <= rsp_aged_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.hit         = rsp_hit_ff;
   assign rsp_ch.rank        = rsp_rank_ff;
   assign rsp_ch.evicted     = rsp_evicted_ff;
   assign rsp_ch.evicted_key = rsp_evkey_ff;
   assign rsp_ch.aged        = rsp_aged_ff;

endmodule
